### src/skct_pkg.sv
package skct_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int KEY_W = 64;
    localparam int AMT_W = 16;
    localparam int OUT_CNT_W = 16;
    localparam int USED_W = 9;
    localparam int DOC_W = 16;
    localparam logic [DOC_W-1:0] DOC_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MERGE  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_INCREMENTED = 3'd1,
        ST_DECREMENTED = 3'd2,
        ST_ERASED      = 3'd3,
        ST_ABSENT      = 3'd4,
        ST_FULL        = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [OUT_CNT_W-1:0] new_count;
        logic [USED_W-1:0]    entries_used;
        logic [DOC_W-1:0]     document_total;
    } out_item_t;

    // classified work handed from front to back
    typedef struct packed {
        logic             is_valid_cmd;
        logic             is_remove;
        logic             is_add;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] add_amount;
    } job_t;

endpackage

### src/skct_front.sv
module skct_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  skct_pkg::in_item_t in_item,
    output logic               q_valid,
    input  logic               q_stall,
    output skct_pkg::job_t     q_job
);

    // two-entry queue
    skct_pkg::job_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    skct_pkg::job_t job;
    logic push, pop;

    always_comb
    begin
        job.is_valid_cmd = (in_item.command != skct_pkg::CMD_NONE);
        job.is_remove    = (in_item.command == skct_pkg::CMD_REMOVE);
        job.is_add       = (in_item.command == skct_pkg::CMD_ADD);
        job.key          = in_item.key;
        job.add_amount   = job.is_add ? skct_pkg::AMT_W'(1) : in_item.amount;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && !q_stall;
    assign q_job    = slot_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        if (push)
        begin
            wr_next = ~wr_reg;
        end
        if (pop)
        begin
            rd_next = ~rd_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= job;
        end
    end

endmodule

### src/skct_back.sv
module skct_back #(
    parameter int TABLE_DEPTH = skct_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = skct_pkg::DEF_COUNT_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_stall,
    input  skct_pkg::job_t      q_job,
    output logic                out_valid,
    input  logic                out_stall,
    output skct_pkg::out_item_t out_item
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [skct_pkg::KEY_W-1:0] key;
        logic [COUNT_WIDTH-1:0]     count;
    } entry_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_SHUP  = 6'b001000,
        S_SHDN  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    state_t state_reg, state_next;
    skct_pkg::job_t job_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [skct_pkg::DOC_W-1:0] doc_reg, doc_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic [FW-1:0] pos_reg, pos_next;
    logic [FW-1:0] rd_idx;
    logic          rd_en;
    logic          we;
    logic [AW-1:0] wa;
    entry_t        wd;
    logic          rvalid_reg;
    logic          lat_reg, lat_next;
    logic [2:0]    st_reg, st_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic          ov_reg, ov_next;
    skct_pkg::out_item_t res_reg, res_next;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] amt_sat;

    assign q_stall   = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_item  = res_reg;

    always_comb
    begin
        if (COUNT_WIDTH >= skct_pkg::AMT_W)
        begin
            amt_sat = COUNT_WIDTH'(job_reg.add_amount);
        end
        else
        begin
            amt_sat = (job_reg.add_amount > skct_pkg::AMT_W'(CNT_MAX))
                      ? CNT_MAX : COUNT_WIDTH'(job_reg.add_amount);
        end
        sum = {1'b0, rdata_reg.count} + {1'b0, amt_sat};
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        doc_next   = doc_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        lat_next   = lat_reg;
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_idx     = idx_reg;
        we         = 1'b0;
        wa         = AW'(pos_reg);
        wd         = '{key: job_reg.key, count: cnt_reg};
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    idx_next   = '0;
                    lat_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // linear search for first key not below the item key
                if (lat_reg && rvalid_reg && rdata_reg.key >= job_reg.key)
                begin
                    state_next = S_EXEC;
                    pos_next   = idx_reg - FW'(1);
                end
                else if (idx_reg == fill_reg)
                begin
                    state_next = S_EXEC;
                    pos_next   = fill_reg;
                    lat_next   = 1'b0;
                end
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + FW'(1);
                    lat_next = 1'b1;
                end
            end
            S_EXEC:
            begin
                // lat_reg marks that rdata holds the entry at pos
                st_next  = skct_pkg::ST_ABSENT;
                cnt_next = '0;
                state_next = S_DONE;
                if (!job_reg.is_valid_cmd)
                begin
                end
                else if (job_reg.is_remove)
                begin
                    if (doc_reg != '0)
                    begin
                        doc_next = doc_reg - 1'b1;
                    end
                    if (lat_reg && rdata_reg.key == job_reg.key)
                    begin
                        if (rdata_reg.count <= COUNT_WIDTH'(1))
                        begin
                            st_next    = skct_pkg::ST_ERASED;
                            idx_next   = pos_reg + FW'(1);
                            lat_next   = 1'b0;
                            state_next = S_SHDN;
                        end
                        else
                        begin
                            st_next  = skct_pkg::ST_DECREMENTED;
                            cnt_next = rdata_reg.count - 1'b1;
                            we = 1'b1;
                            wd = '{key: job_reg.key, count: rdata_reg.count - 1'b1};
                        end
                    end
                end
                else if (lat_reg && rdata_reg.key == job_reg.key)
                begin
                    st_next  = skct_pkg::ST_INCREMENTED;
                    cnt_next = sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0];
                    we = 1'b1;
                    wd = '{key: job_reg.key,
                           count: sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0]};
                    if (job_reg.is_add && doc_reg != skct_pkg::DOC_MAX)
                    begin
                        doc_next = doc_reg + 1'b1;
                    end
                end
                else if (job_reg.add_amount == '0)
                begin
                end
                else if (fill_reg == FW'(TABLE_DEPTH))
                begin
                    st_next = skct_pkg::ST_FULL;
                end
                else
                begin
                    st_next  = skct_pkg::ST_INSERTED;
                    cnt_next = amt_sat;
                    if (job_reg.is_add && doc_reg != skct_pkg::DOC_MAX)
                    begin
                        doc_next = doc_reg + 1'b1;
                    end
                    idx_next   = fill_reg;
                    lat_next   = 1'b0;
                    state_next = S_SHUP;
                end
            end
            S_SHUP:
            begin
                // move entries up one place, top first: read idx-1, write idx
                if (lat_reg)
                begin
                    we = 1'b1;
                    wa = AW'(idx_reg + FW'(1));
                    wd = rdata_reg;
                    lat_next = 1'b0;
                end
                else if (idx_reg == pos_reg)
                begin
                    we = 1'b1;
                    wd = '{key: job_reg.key, count: cnt_reg};
                    fill_next  = fill_reg + FW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_reg - FW'(1);
                    idx_next = idx_reg - FW'(1);
                    lat_next = 1'b1;
                end
            end
            S_SHDN:
            begin
                // move entries down one place: read idx, write idx-1
                if (lat_reg)
                begin
                    we = 1'b1;
                    wa = AW'(idx_reg - FW'(1));
                    wd = rdata_reg;
                    lat_next = 1'b0;
                    idx_next = idx_reg + FW'(1);
                end
                else if (idx_reg == fill_reg)
                begin
                    fill_next  = fill_reg - FW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    lat_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next                 = 1'b1;
                    res_next.status         = st_reg;
                    res_next.new_count      = skct_pkg::OUT_CNT_W'(cnt_reg);
                    res_next.entries_used   = skct_pkg::USED_W'(fill_reg);
                    res_next.document_total = doc_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[AW'(rd_idx)];
        end
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (state_reg == S_IDLE && q_valid)
        begin
            job_reg <= q_job;
        end
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        cnt_reg <= cnt_next;
        st_reg  <= st_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            doc_reg    <= '0;
            ov_reg     <= 1'b0;
            lat_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            doc_reg    <= doc_next;
            ov_reg     <= ov_next;
            lat_reg    <= lat_next;
            rvalid_reg <= rd_en;
        end
    end

endmodule

### src/sorted_key_count_table.sv
// channel | direction | payload                 | handshake
// in      | input     | skct_pkg::in_item_t     | in_valid / in_stall
// out     | output    | skct_pkg::out_item_t    | out_valid / out_stall
//
// one item at a time in the back end; the front queue holds two items
// a lookup reads the sorted table one entry a cycle up to the first key not below
// the item key; an insert or erase then shifts the tail one entry at a time,
// reading each entry and then writing it one place up or down
// reset clears the fill level, the document total and all handshake state
// a stalled result holds in the output register; the queue keeps accepting until it holds two items
module sorted_key_count_table #(
    parameter int TABLE_DEPTH = skct_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = skct_pkg::DEF_COUNT_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  skct_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output skct_pkg::out_item_t out_item
);

    // queue between classifier and table engine
    logic           q_valid;
    logic           q_stall;
    skct_pkg::job_t q_job;

    skct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_stall  (q_stall),
        .q_job    (q_job)
    );

    // table engine: search, update, shift
    skct_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_stall   (q_stall),
        .q_job     (q_job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // fill level never exceeds table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_item.entries_used) <= TABLE_DEPTH))
        else $error("entries_used above depth");

    // a table-full answer carries zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status == skct_pkg::ST_FULL) |-> out_item.new_count == '0)
        else $error("full status with nonzero count");

    // erase or absent report zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status == skct_pkg::ST_ERASED
                       || out_item.status == skct_pkg::ST_ABSENT))
        |-> out_item.new_count == '0)
        else $error("erase or absent with nonzero count");

endmodule
